/* hdl/ipv6tf_pkg.sv */
package ipv6tf_pkg;

  localparam int NUM_WORDS = 8;
  localparam int WORD_W    = 16;
  localparam int CHAR_W    = 7;

  localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_HEX_A = 7'h57;  // 'a' - 10

  // Microcode address
  typedef logic [4:0] upc_t;

  localparam upc_t U_IDLE     = 5'd0;
  localparam upc_t U_GRP      = 5'd1;
  localparam upc_t U_RUN_CHK  = 5'd2;
  localparam upc_t U_RUN_LEAD = 5'd3;
  localparam upc_t U_RUN_COL  = 5'd4;
  localparam upc_t U_RUN_SET  = 5'd5;
  localparam upc_t U_WRITE    = 5'd6;
  localparam upc_t U_END_RUN  = 5'd7;
  localparam upc_t U_HEX_INIT = 5'd8;
  localparam upc_t U_HEX      = 5'd9;
  localparam upc_t U_SEP_CHK  = 5'd10;
  localparam upc_t U_SEP      = 5'd11;
  localparam upc_t U_NEXT     = 5'd12;
  localparam upc_t U_FIN      = 5'd13;
  localparam upc_t U_FIN_COL  = 5'd14;
  localparam upc_t U_DEC_INIT = 5'd15;
  localparam upc_t U_DEC      = 5'd16;
  localparam upc_t U_DEC_CHK  = 5'd17;
  localparam upc_t U_DOT      = 5'd18;

  typedef enum logic [2:0] {
    E_NONE,
    E_COLON,
    E_DOT,
    E_HEX,
    E_DEC
  } emit_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_MAP6,
    C_NOT_ZRUN,
    C_RUN_QUIET,
    C_NOT_IN_RUN,
    C_HEX_MORE,
    C_LAST_GRP,
    C_GRP_MORE,
    C_DEC_MORE,
    C_LAST_BYTE
  } cond_t;

  typedef enum logic [3:0] {
    A_NOP,
    A_LOAD,
    A_SET_RUN,
    A_END_RUN,
    A_HEX_INIT,
    A_HEX_STEP,
    A_SHIFT,
    A_DEC_INIT,
    A_DEC_STEP,
    A_NEXT_BYTE
  } act_t;

  typedef enum logic [1:0] {
    L_NO,
    L_ALWAYS,
    L_HEX_END,
    L_DEC_END
  } last_t;

  typedef struct packed {
    emit_t emit;
    cond_t cond;
    upc_t  target;
    act_t  act;
    last_t last;
  } ucode_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic map6;
    logic zrun;
    logic run_quiet;
    logic in_run;
    logic hex_more;
    logic last_grp;
    logic dec_more;
    logic last_byte;
    logic hex_end;
    logic dec_end;
  } dp_status_t;

endpackage

/* hdl/ipv6tf_rom.sv */
module ipv6tf_rom
  import ipv6tf_pkg::*;
(
  input  upc_t   upc,
  output ucode_t uc
);

  always_comb begin
    uc = '{emit: E_NONE, cond: C_ALWAYS, target: U_IDLE, act: A_NOP, last: L_NO};
    case (upc)
      U_IDLE:     uc = '{E_NONE,  C_NO_IN,      U_IDLE,     A_LOAD,      L_NO};
      U_GRP:      uc = '{E_NONE,  C_MAP6,       U_DEC_INIT, A_NOP,       L_NO};
      U_RUN_CHK:  uc = '{E_NONE,  C_NOT_ZRUN,   U_WRITE,    A_NOP,       L_NO};
      U_RUN_LEAD: uc = '{E_NONE,  C_RUN_QUIET,  U_RUN_SET,  A_NOP,       L_NO};
      U_RUN_COL:  uc = '{E_COLON, C_NEVER,      U_IDLE,     A_NOP,       L_NO};
      U_RUN_SET:  uc = '{E_NONE,  C_ALWAYS,     U_NEXT,     A_SET_RUN,   L_NO};
      U_WRITE:    uc = '{E_NONE,  C_NOT_IN_RUN, U_HEX_INIT, A_NOP,       L_NO};
      U_END_RUN:  uc = '{E_COLON, C_NEVER,      U_IDLE,     A_END_RUN,   L_NO};
      U_HEX_INIT: uc = '{E_NONE,  C_NEVER,      U_IDLE,     A_HEX_INIT,  L_NO};
      U_HEX:      uc = '{E_HEX,   C_HEX_MORE,   U_HEX,      A_HEX_STEP,  L_HEX_END};
      U_SEP_CHK:  uc = '{E_NONE,  C_LAST_GRP,   U_NEXT,     A_NOP,       L_NO};
      U_SEP:      uc = '{E_COLON, C_NEVER,      U_IDLE,     A_NOP,       L_NO};
      U_NEXT:     uc = '{E_NONE,  C_GRP_MORE,   U_GRP,      A_SHIFT,     L_NO};
      U_FIN:      uc = '{E_NONE,  C_NOT_IN_RUN, U_IDLE,     A_NOP,       L_NO};
      U_FIN_COL:  uc = '{E_COLON, C_ALWAYS,     U_IDLE,     A_NOP,       L_ALWAYS};
      U_DEC_INIT: uc = '{E_NONE,  C_NEVER,      U_IDLE,     A_DEC_INIT,  L_NO};
      U_DEC:      uc = '{E_DEC,   C_DEC_MORE,   U_DEC,      A_DEC_STEP,  L_DEC_END};
      U_DEC_CHK:  uc = '{E_NONE,  C_LAST_BYTE,  U_IDLE,     A_NOP,       L_NO};
      U_DOT:      uc = '{E_DOT,   C_ALWAYS,     U_DEC,      A_NEXT_BYTE, L_NO};
      default:    uc = '{E_NONE,  C_ALWAYS,     U_IDLE,     A_NOP,       L_NO};
    endcase
  end

endmodule

/* hdl/ipv6tf_datapath.sv */
module ipv6tf_datapath
  import ipv6tf_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  act_t                        act,
  input  emit_t                       emit,
  input  logic [NUM_WORDS*WORD_W-1:0] addr,
  output dp_status_t                  status,
  output logic [CHAR_W-1:0]           ch
);

  logic [WORD_W-1:0] sh [NUM_WORDS];
  logic [2:0] grp;
  logic       in_run;
  logic       run_done;
  logic       mapped;
  logic [1:0] hd;
  logic [1:0] bc;
  logic [1:0] dd;

  logic [7:0]  cur_byte;
  logic [7:0]  nxt_byte;
  logic [11:0] bcd;
  logic [3:0]  nib;
  logic [3:0]  dec_digit;
  logic [1:0]  bc_inc;

  function automatic logic [1:0] ndig(input logic [7:0] b);
    if (b >= 8'd100) begin
      return 2'd2;
    end else if (b >= 8'd10) begin
      return 2'd1;
    end
    return 2'd0;
  endfunction

  function automatic logic [7:0] byte_at(input logic [1:0] idx, input logic [WORD_W-1:0] w6,
                                         input logic [WORD_W-1:0] w7);
    logic [7:0] r;
    case (idx)
      2'd0:    r = w6[15:8];
      2'd1:    r = w6[7:0];
      2'd2:    r = w7[15:8];
      default: r = w7[7:0];
    endcase
    return r;
  endfunction

  // Double dabble, eight narrow steps
  function automatic logic [11:0] bin2bcd(input logic [7:0] b);
    logic [19:0] s;
    s = {12'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
      if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
      if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
      s = {s[18:0], 1'b0};
    end
    return s[19:8];
  endfunction

  assign bc_inc   = bc + 2'd1;
  assign cur_byte = byte_at(bc, sh[0], sh[1]);
  assign nxt_byte = byte_at(bc_inc, sh[0], sh[1]);
  assign bcd      = bin2bcd(cur_byte);
  assign nib      = sh[0][{hd, 2'b00} +: 4];
  assign dec_digit = bcd[{dd, 2'b00} +: 4];

  always_comb begin
    case (emit)
      E_COLON: ch = CH_COLON;
      E_DOT:   ch = CH_DOT;
      E_HEX:   ch = (nib < 4'd10) ? CH_ZERO + {3'd0, nib} : CH_HEX_A + {3'd0, nib};
      E_DEC:   ch = CH_ZERO + {3'd0, dec_digit};
      default: ch = CH_COLON;
    endcase
  end

  always_comb begin
    status.map6      = mapped && (grp == 3'd6);
    status.zrun      = (sh[0] == '0) && (in_run || sh[1] == '0) && !run_done;
    status.run_quiet = in_run || (grp != 3'd0);
    status.in_run    = in_run;
    status.hex_more  = (hd != 2'd0);
    status.last_grp  = (grp == 3'd7);
    status.dec_more  = (dd != 2'd0);
    status.last_byte = (bc == 2'd3);
    status.hex_end   = (grp == 3'd7) && (hd == 2'd0);
    status.dec_end   = (bc == 2'd3) && (dd == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (act)
        A_LOAD: begin
          for (int k = 0; k < NUM_WORDS; k++) begin
            sh[k] <= addr[k*WORD_W +: WORD_W];
          end
        end
        A_SHIFT: begin
          for (int k = 0; k < NUM_WORDS - 1; k++) begin
            sh[k] <= sh[k+1];
          end
          sh[NUM_WORDS-1] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp      <= '0;
      in_run   <= 1'b0;
      run_done <= 1'b0;
      mapped   <= 1'b0;
      hd       <= '0;
      bc       <= '0;
      dd       <= '0;
    end else if (en) begin
      case (act)
        A_LOAD: begin
          grp      <= '0;
          in_run   <= 1'b0;
          run_done <= 1'b0;
          mapped   <= (addr[5*WORD_W-1:0] == '0) && (addr[6*WORD_W-1:5*WORD_W] == 16'hFFFF);
        end
        A_SET_RUN:   in_run <= 1'b1;
        A_END_RUN: begin
          in_run   <= 1'b0;
          run_done <= 1'b1;
        end
        A_HEX_INIT: begin
          if (sh[0][15:12] != 4'd0) begin
            hd <= 2'd3;
          end else if (sh[0][11:8] != 4'd0) begin
            hd <= 2'd2;
          end else if (sh[0][7:4] != 4'd0) begin
            hd <= 2'd1;
          end else begin
            hd <= 2'd0;
          end
        end
        A_HEX_STEP:  hd <= hd - 2'd1;
        A_SHIFT:     grp <= grp + 3'd1;
        A_DEC_INIT: begin
          bc <= 2'd0;
          dd <= ndig(byte_at(2'd0, sh[0], sh[1]));
        end
        A_DEC_STEP:  dd <= dd - 2'd1;
        A_NEXT_BYTE: begin
          bc <= bc_inc;
          dd <= ndig(nxt_byte);
        end
        default: ;
      endcase
    end
  end

endmodule

/* hdl/ipv6_text_formatter.sv */
// IPv6 address to text. One request on the s_ side carries a whole address as
// eight 16-bit groups; the block answers with its text form on the m_ side, one
// ASCII character per request, tlast on the final one. Groups are lowercase hex
// without leading zeros, colon separated. The first run of two or more zero
// groups (scanning from group 0, not the longest run) collapses to "::"; a
// zero last group counts as the start of such a run when none has been taken
// yet. ::ffff:a.b.c.d addresses end in dotted decimal. Text length is 2 to 39
// characters. A small microcode program steps one control word per cycle
// while no character step waits for room in the output register. The next
// address is taken only once the program is back at its idle step. That is
// the step right after a trailing "::" colon, the step after the byte check
// that follows the last dotted decimal digit, and the step after the
// separator check, shift and finish steps that follow the last hex digit
// of group 7.
module ipv6_text_formatter
  import ipv6tf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // word_0[15:0], word_1, ... word_7[127:112]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,   // out_char[6:0], zero[7]
  output logic         m_tlast    // is_last
);

  upc_t        upc;
  upc_t        upc_next;
  ucode_t      uc;
  dp_status_t  st;
  logic [CHAR_W-1:0] ch;
  logic        emits;
  logic        out_free;
  logic        go;
  logic        take;
  logic        dp_en;
  logic        last_char;

  ipv6tf_rom u_rom (
    .upc (upc),
    .uc  (uc)
  );

  ipv6tf_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .en     (dp_en),
    .act    (uc.act),
    .emit   (uc.emit),
    .addr   (s_tdata),
    .status (st),
    .ch     (ch)
  );

  // New address requests are taken only at the idle step.
  assign s_tready = (upc == U_IDLE);

  // A step that writes a character waits for room in the output register.
  assign emits    = (uc.emit != E_NONE);
  assign out_free = !m_tvalid || m_tready;
  assign go       = !emits || out_free;
  assign dp_en    = go && !(uc.act == A_LOAD && !s_tvalid);

  // Branch condition select
  always_comb begin
    case (uc.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_IN:      take = !s_tvalid;
      C_MAP6:       take = st.map6;
      C_NOT_ZRUN:   take = !st.zrun;
      C_RUN_QUIET:  take = st.run_quiet;
      C_NOT_IN_RUN: take = !st.in_run;
      C_HEX_MORE:   take = st.hex_more;
      C_LAST_GRP:   take = st.last_grp;
      C_GRP_MORE:   take = !st.last_grp;
      C_DEC_MORE:   take = st.dec_more;
      C_LAST_BYTE:  take = st.last_byte;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    upc_next = upc;
    if (go) begin
      upc_next = take ? uc.target : upc + 5'd1;
    end
  end

  // Final character marker
  always_comb begin
    case (uc.last)
      L_ALWAYS:  last_char = 1'b1;
      L_HEX_END: last_char = st.hex_end;
      L_DEC_END: last_char = st.dec_end;
      default:   last_char = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // Output register: decouples the program from the downstream stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go && emits) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emits) begin
      m_tdata <= {1'b0, ch};
      m_tlast <= last_char;
    end
  end

endmodule

/* hdl/ipv6tf_checker.sv */
module ipv6tf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [7:0]   m_tdata,
  input logic         m_tlast
);

  // stalled character holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // only hex digits, colon or dot
  a_charset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata >= 8'h30 && m_tdata <= 8'h3A) ||
                 (m_tdata >= 8'h61 && m_tdata <= 8'h66) || (m_tdata == 8'h2E))
    else $error("bad output character");

  // no new address while the current text is unfinished
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready mid text");

  a_one_addr: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accept");

endmodule

bind ipv6_text_formatter ipv6tf_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import ipv6tf_pkg::*;

  // One request in = one address (eight groups, group 0 in the low bits).
  // One request out = one text character, tlast on the final one.
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] addr_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  localparam int RAND_ADDRS  = 280;
  localparam int IDLE_LIMIT  = 4000;  // cycles with no request moving on either side
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int HOLD_AT     = 60;    // addresses taken before the hold-off starts
  localparam int DRAIN_WAIT  = 100;   // a bit over the slowest address

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // word_0[15:0], word_1, ... word_7[127:112]
  logic         m_tvalid;
  logic         m_tready;
  logic [7:0]   m_tdata;   // out_char[6:0], zero[7]
  logic         m_tlast;   // is_last

  ipv6_text_formatter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_char_t        pending_chars[$];  // characters still owed by the block
  logic [CHAR_W-1:0] text_buf[$];       // scratch for the formatter model
  addr_t             dir_addr[$];
  string             dir_text[$];       // "" means: use the formatter model

  int errors        = 0;
  int addrs_in      = 0;
  int mapped_in     = 0;
  int chars_checked = 0;
  bit hold_done     = 1'b0;

  task automatic report_err(input string msg);
    errors++;
    if (errors <= 100)
      $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic addr_t mk(input logic [15:0] w0, w1, w2, w3, w4, w5, w6, w7);
    mk = {w7, w6, w5, w4, w3, w2, w1, w0};
  endfunction

  // one byte in decimal, no leading zeros
  task automatic put_dec(input logic [7:0] b);
    int v;
    v = int'(b);
    if (v >= 100) text_buf.push_back(CH_ZERO + CHAR_W'(v / 100));
    if (v >= 10)  text_buf.push_back(CH_ZERO + CHAR_W'((v / 10) % 10));
    text_buf.push_back(CH_ZERO + CHAR_W'(v % 10));
  endtask

  // Formatter model: builds the text of one address and queues it.
  task automatic queue_addr_text(input addr_t a);
    logic [15:0] w[NUM_WORDS+1];
    logic [15:0] nxt;
    logic [3:0]  nib;
    logic        mapped, in_run, run_done, started;
    text_char_t  tc;
    text_buf.delete();
    for (int i = 0; i < NUM_WORDS; i++) w[i] = a[i];
    w[NUM_WORDS] = '0;  // lookahead past group 7 reads as zero
    mapped = (w[0] == 0) && (w[1] == 0) && (w[2] == 0) && (w[3] == 0) &&
             (w[4] == 0) && (w[5] == 16'hffff);
    in_run   = 1'b0;
    run_done = 1'b0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (i == 6 && mapped) begin
        put_dec(w[6][15:8]);
        text_buf.push_back(CH_DOT);
        put_dec(w[6][7:0]);
        text_buf.push_back(CH_DOT);
        put_dec(w[7][15:8]);
        text_buf.push_back(CH_DOT);
        put_dec(w[7][7:0]);
        break;
      end
      nxt = in_run ? 16'h0 : w[i+1];
      if (w[i] == 0 && nxt == 0 && !run_done) begin
        if (!in_run) begin
          in_run = 1'b1;
          if (i == 0) text_buf.push_back(CH_COLON);
        end
      end else begin
        if (in_run) begin
          in_run   = 1'b0;
          run_done = 1'b1;
          text_buf.push_back(CH_COLON);
        end
        started = 1'b0;
        for (int s = 3; s >= 0; s--) begin
          nib = w[i][s*4 +: 4];
          if (nib != 0 || started || s == 0) begin
            started = 1'b1;
            text_buf.push_back(nib < 10 ? CH_ZERO + CHAR_W'(nib) : CH_HEX_A + CHAR_W'(nib));
          end
        end
        if (i < NUM_WORDS - 1) text_buf.push_back(CH_COLON);
      end
    end
    if (in_run) text_buf.push_back(CH_COLON);
    for (int k = 0; k < text_buf.size(); k++) begin
      tc.ch   = text_buf[k];
      tc.last = (k == text_buf.size() - 1);
      pending_chars.push_back(tc);
    end
  endtask

  // typed-in text for the directed rows
  task automatic queue_literal(input string txt);
    text_char_t tc;
    for (int k = 0; k < txt.len(); k++) begin
      tc.ch   = CHAR_W'(txt[k]);
      tc.last = (k == txt.len() - 1);
      pending_chars.push_back(tc);
    end
  endtask

  // random address: mostly zero-rich group mixes, plus mapped and near-mapped
  function automatic addr_t rand_addr();
    addr_t a;
    int    kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (kind < 25)
        a[i] = 16'($urandom_range(0, 65535));
      else if ($urandom_range(0, 99) < 45)
        a[i] = '0;
      else
        a[i] = 16'($urandom_range(0, 65535) >> (4 * $urandom_range(0, 3)));
    end
    if (kind < 15) begin
      // mapped: dotted bytes of varied digit counts
      for (int i = 0; i < 5; i++) a[i] = '0;
      a[5] = 16'hffff;
      a[6] = {8'($urandom_range(0, 255) >> $urandom_range(0, 7)),
              8'($urandom_range(0, 255) >> $urandom_range(0, 7))};
      a[7] = {8'($urandom_range(0, 255) >> $urandom_range(0, 7)),
              8'($urandom_range(0, 255) >> $urandom_range(0, 7))};
      if (kind < 4) a[7] = 16'($urandom_range(0, 65535));
    end else if (kind < 20) begin
      // near-mapped: one prefix group off, or the ffff marker off by a bit
      for (int i = 0; i < 5; i++) a[i] = '0;
      a[5] = 16'hffff;
      if ($urandom_range(0, 1))
        a[$urandom_range(0, 4)] = 16'($urandom_range(1, 65535));
      else
        a[5][$urandom_range(0, 15)] = 1'b0;
    end
    return a;
  endfunction

  // Offer one request and hold it until taken. Valid is left high for the
  // caller to drop at the start of a gap.
  task automatic send_addr(input addr_t a, input string txt);
    s_tdata  <= a;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    addrs_in++;
    if (a[0] == 0 && a[1] == 0 && a[2] == 0 && a[3] == 0 && a[4] == 0 &&
        a[5] == 16'hffff)
      mapped_in++;
    if (txt.len() != 0)
      queue_literal(txt);
    else
      queue_addr_text(a);
  endtask

  // Receiver: changes stall pattern every so often, plus one long hold-off
  // while the sender keeps pushing, so the block backs up into s_tready.
  initial begin
    int mode, mode_left, phase;
    m_tready  <= 1'b0;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!hold_done && addrs_in >= HOLD_AT) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (phase % 4 != 0);
        endcase
      end
    end
  end

  // Output check: every character taken is matched against the oldest owed one.
  always @(posedge clk) begin
    text_char_t tc;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        report_err($sformatf("unexpected char %02h last %b", m_tdata, m_tlast));
      end else begin
        tc = pending_chars.pop_front();
        chars_checked++;
        if (m_tdata !== {1'b0, tc.ch} || m_tlast !== tc.last)
          report_err($sformatf("char %02h last %b, expected %02h last %b",
                               m_tdata, m_tlast, {1'b0, tc.ch}, tc.last));
      end
    end
  end

  // Watchdog: too long with no request moving on either side.
  always @(posedge clk) begin
    int idle_cycles;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d chars still owed",
                 IDLE_LIMIT, pending_chars.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int burst_left, gap;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: text typed in where obvious, else from the model.
    dir_addr.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));  // all zero
    dir_text.push_back("::");
    dir_addr.push_back(mk(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                          16'hffff, 16'hffff, 16'hffff, 16'hffff));  // longest text
    dir_text.push_back("ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff");
    dir_addr.push_back(mk(1, 2, 3, 4, 5, 6, 7, 0));  // lone trailing zero opens a run
    dir_text.push_back("1:2:3:4:5:6:7::");
    dir_addr.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1));
    dir_text.push_back("::1");
    dir_addr.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0));  // run up to the end
    dir_text.push_back("1::");
    dir_addr.push_back(mk(0, 0, 0, 0, 0, 16'hffff, 16'hc0a8, 16'h0101));
    dir_text.push_back("::ffff:192.168.1.1");
    dir_addr.push_back(mk(0, 0, 0, 0, 0, 16'hffff, 0, 0));
    dir_text.push_back("::ffff:0.0.0.0");
    dir_addr.push_back(mk(0, 0, 0, 0, 0, 16'hffff, 16'hffff, 16'hffff));
    dir_text.push_back("::ffff:255.255.255.255");
    dir_addr.push_back(mk(1, 0, 2, 0, 3, 0, 4, 0));
    dir_text.push_back("1:0:2:0:3:0:4::");
    dir_addr.push_back(mk(1, 0, 0, 2, 0, 0, 0, 3));  // first run wins, not longest
    dir_text.push_back("");
    dir_addr.push_back(mk(0, 0, 1, 0, 0, 0, 0, 2));
    dir_text.push_back("");
    dir_addr.push_back(mk(0, 1, 0, 1, 0, 1, 0, 1));  // single zeros stay "0"
    dir_text.push_back("");
    dir_addr.push_back(mk(0, 0, 1, 0, 0, 2, 0, 0));  // later runs written out
    dir_text.push_back("");
    dir_addr.push_back(mk(16'h0abc, 16'h00f0, 16'h000f, 16'h1000,
                          16'h0001, 16'h0010, 16'h0100, 16'h8000));
    dir_text.push_back("");
    dir_addr.push_back(mk(0, 0, 0, 0, 1, 16'hffff, 16'hc0a8, 16'h0101));  // not mapped
    dir_text.push_back("");
    dir_addr.push_back(mk(0, 0, 0, 0, 0, 16'hfffe, 16'h0a00, 16'h0009));  // not mapped
    dir_text.push_back("");
    dir_addr.push_back(mk(0, 0, 0, 0, 0, 16'hffff, 16'h0a00, 16'h6409));
    dir_text.push_back("");
    dir_addr.push_back(mk(16'hffff, 0, 0, 0, 0, 0, 0, 16'hffff));
    dir_text.push_back("");
    dir_addr.push_back(mk(0, 0, 0, 0, 0, 0, 16'hffff, 0));
    dir_text.push_back("");
    dir_addr.push_back(mk(16'h8000, 0, 0, 0, 0, 0, 0, 16'h0001));
    dir_text.push_back("");

    // Sender: bursts of random length, random gaps (sometimes none).
    burst_left = 0;
    for (int n = 0; n < dir_addr.size() + RAND_ADDRS; n++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0 && n != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      if (n < dir_addr.size())
        send_addr(dir_addr[n], dir_text[n]);
      else
        send_addr(rand_addr(), "");
    end
    s_tvalid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d addresses (%0d directed, %0d mapped), %0d characters checked",
             addrs_in, dir_addr.size(), mapped_in, chars_checked);
    $display("receiver hold-off of %0d cycles %0s, %0d mismatches",
             HOLD_CYCLES, hold_done ? "done" : "not reached", errors);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
